/* hw/rtl/pic_pkg.sv */
// pic_pkg: shared types and constants for the priority interrupt controller
// depends on nothing; imported by pic_ctrl, pic_datapath and the core top level
package pic_pkg;

  localparam int NUM_LINES = 8;
  localparam logic [7:0] LINE_MASK = 8'((1 << NUM_LINES) - 1);
  localparam logic [7:0] LB_OPCODE = 8'hC0;
  localparam logic [7:0] BASE_MASK = 8'hF0;
  localparam int CTRL_KEEP_PEND_BIT = 3;
  localparam int CTRL_KEEP_MASK_BIT = 2;

  typedef enum logic [2:0] {
    ACT_LINE_REQ   = 3'd0,
    ACT_WR_MASK    = 3'd1,
    ACT_WR_PAGE    = 3'd2,
    ACT_WR_CTRL    = 3'd3,
    ACT_RD_STATUS  = 3'd4,
    ACT_RD_POLL    = 3'd5,
    ACT_RD_VECTOR  = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    VB_OPCODE = 2'd0,
    VB_PAGE   = 2'd1,
    VB_POLL   = 2'd2,
    VB_END    = 2'd3
  } vb_sel_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } pic_cmd_t;

endpackage

/* hw/rtl/pic_ctrl.sv */
// pic_ctrl: handshake sequencer for the interrupt controller
// depends on pic_pkg; drives the datapath through pic_cmd_t
module pic_ctrl
  import pic_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pic_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_xor_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({in_ready, out_valid}))
    else $error("in_ready and out_valid overlap");
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item gave no result");
  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid && in_ready))
    else $error("result not retired after handshake");
`endif

endmodule

/* hw/rtl/pic_datapath.sv */
// pic_datapath: interrupt state registers, priority select and result register
// depends on pic_pkg; commanded by pic_ctrl
module pic_datapath
  import pic_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pic_cmd_t   cmd,
  input  logic [2:0] in_action,
  input  logic [7:0] in_write_data,
  input  logic [2:0] in_line_index,
  input  logic       in_line_level,
  input  logic       in_freeze_vector,
  input  logic       in_debug_access,
  input  logic [1:0] in_debug_offset,
  output logic [7:0] out_read_data,
  output logic       out_read_valid
);

  logic [7:0] pending_r, pending_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] page_r, page_nxt;
  logic [1:0] ivl_r, ivl_nxt;
  logic [3:0] base_r, base_nxt;
  logic [1:0] step_r, step_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic       rvalid_r, rvalid_nxt;

  logic [7:0] ready_lines;
  logic [2:0] win_line;
  logic       win_found;
  logic [7:0] poll_byte;
  logic [7:0] win_onehot;
  logic [7:0] req_onehot;
  logic       req_in_range;
  logic [1:0] vb_which;
  act_t       act;

  // lowest ready line wins
  always_comb begin
    ready_lines = pending_r & ~mask_r & LINE_MASK;
    win_line    = '0;
    win_found   = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (ready_lines[i] && !win_found) begin
        win_line  = 3'(i);
        win_found = 1'b1;
      end
    end
    win_onehot = win_found ? (8'd1 << win_line) : 8'd0;
    poll_byte  = 8'({5'd0, win_line} << ({1'b0, ivl_r} + 3'd1))
               | ({base_r, 4'd0} & 8'(BASE_MASK << ivl_r));
  end

  always_comb begin
    act          = act_t'(in_action);
    req_in_range = ({1'b0, in_line_index} < 4'(NUM_LINES));
    req_onehot   = 8'd1 << in_line_index;
    vb_which     = in_debug_access ? in_debug_offset : step_r;

    pending_nxt = pending_r;
    mask_nxt    = mask_r;
    page_nxt    = page_r;
    ivl_nxt     = ivl_r;
    base_nxt    = base_r;
    step_nxt    = step_r;
    rdata_nxt   = 8'd0;
    rvalid_nxt  = 1'b0;

    case (act)
      ACT_LINE_REQ: begin
        if (req_in_range) begin
          pending_nxt = in_line_level ? (pending_r | req_onehot) : (pending_r & ~req_onehot);
        end
      end
      ACT_WR_MASK: mask_nxt = in_write_data & LINE_MASK;
      ACT_WR_PAGE: page_nxt = in_write_data;
      ACT_WR_CTRL: begin
        ivl_nxt  = in_write_data[1:0];
        base_nxt = in_write_data[7:4];
        if (!in_write_data[CTRL_KEEP_PEND_BIT]) pending_nxt = 8'd0;
        if (!in_write_data[CTRL_KEEP_MASK_BIT]) mask_nxt = 8'd0;
      end
      ACT_RD_STATUS: begin
        step_nxt   = 2'd0;
        rdata_nxt  = pending_r & LINE_MASK;
        rvalid_nxt = 1'b1;
      end
      ACT_RD_POLL: begin
        step_nxt    = 2'd0;
        rdata_nxt   = poll_byte;
        pending_nxt = pending_r & ~win_onehot;
        rvalid_nxt  = 1'b1;
      end
      ACT_RD_VECTOR: begin
        rvalid_nxt = 1'b1;
        if (!in_debug_access && step_r != VB_END && !in_freeze_vector) begin
          step_nxt = step_r + 2'd1;
        end
        unique case (vb_sel_t'(vb_which))
          VB_OPCODE: rdata_nxt = LB_OPCODE;
          VB_PAGE:   rdata_nxt = page_r;
          VB_POLL: begin
            rdata_nxt   = poll_byte;
            pending_nxt = pending_r & ~win_onehot;
          end
          VB_END:    rdata_nxt = 8'd0;
          default:   rdata_nxt = 8'd0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= LINE_MASK;
      mask_r    <= '0;
      page_r    <= '0;
      ivl_r     <= '0;
      base_r    <= '0;
      step_r    <= '0;
    end else if (cmd.exec) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      page_r    <= page_nxt;
      ivl_r     <= ivl_nxt;
      base_r    <= base_nxt;
      step_r    <= step_nxt;
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r  <= rdata_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  assign out_read_data  = rdata_r;
  assign out_read_valid = rvalid_r;

endmodule

/* hw/rtl/priority_interrupt_controller_core.sv */
// the result is registered and shown from the cycle after its item is accepted
// the result register holds one item, and a new item is taken only after the previous
// result has been handed off
// reset: synchronous active-low rst_n; all lines pending, mask, page, interval,
// base nibble and vector step cleared, no result waiting
module priority_interrupt_controller_core
  import pic_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one action per item
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_write_data,
  input  logic [2:0] in_line_index,
  input  logic       in_line_level,
  input  logic       in_freeze_vector,
  input  logic       in_debug_access,
  input  logic [1:0] in_debug_offset,
  // result channel: exactly one item per accepted input item
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_read_valid
);

  // command from sequencer to datapath
  pic_cmd_t cmd;

  // sequencer: idle until an item arrives, then hold the result until taken
  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: the item is applied in its accept cycle, state and result
  // register update together at that edge
  pic_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_write_data    (in_write_data),
    .in_line_index    (in_line_index),
    .in_line_level    (in_line_level),
    .in_freeze_vector (in_freeze_vector),
    .in_debug_access  (in_debug_access),
    .in_debug_offset  (in_debug_offset),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid)
  );

endmodule

/* test/pic_core_checker.sv */
`timescale 1ns / 100ps
// pic_core_checker: watches the action and result channels of the interrupt controller core,
// predicts every read result from its own copy of the registers and compares; uses pic_pkg
module pic_core_checker
  import pic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_write_data,
  input  logic [2:0]  in_line_index,
  input  logic        in_line_level,
  input  logic        in_freeze_vector,
  input  logic        in_debug_access,
  input  logic [1:0]  in_debug_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic        out_read_valid,
  input  logic        end_check,
  output int unsigned outstanding,
  output int unsigned error_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_read;
  } read_res_t;

  read_res_t  expected_reads_q[$];

  // predicted controller registers
  logic [7:0] pend_q;
  logic [7:0] mask_q;
  logic [7:0] page_q;
  logic [1:0] ivl_q;
  logic [3:0] base_q;
  vb_sel_t    vstep_q;

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
  endtask

  // lowest ready line wins and is cleared; no ready line gives line 0
  function automatic logic [7:0] take_poll_byte();
    logic [7:0] rdy;
    logic [2:0] sel;
    bit         found;
    rdy   = pend_q & ~mask_q & LINE_MASK;
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (!found && rdy[i]) begin
        sel   = 3'(i);
        found = 1'b1;
      end
    end
    if (found) pend_q[sel] = 1'b0;
    return (8'(sel) << (ivl_q + 1)) | ({base_q, 4'h0} & (BASE_MASK << ivl_q));
  endfunction

  function automatic logic [7:0] vector_byte_at(input vb_sel_t which);
    case (which)
      VB_OPCODE: return LB_OPCODE;
      VB_PAGE:   return page_q;
      VB_POLL:   return take_poll_byte();
      default:   return 8'h00;
    endcase
  endfunction

  function automatic read_res_t predict_access(input logic [2:0] act, input logic [7:0] data,
                                               input logic [2:0] line, input logic lvl,
                                               input logic frz, input logic dbg,
                                               input logic [1:0] off);
    read_res_t r;
    vb_sel_t   s;
    r = '0;
    case (act)
      ACT_LINE_REQ: begin
        if (int'(line) < NUM_LINES) pend_q[line] = lvl;
      end
      ACT_WR_MASK: mask_q = data & LINE_MASK;
      ACT_WR_PAGE: page_q = data;
      ACT_WR_CTRL: begin
        ivl_q  = data[1:0];
        base_q = data[7:4];
        if (!data[CTRL_KEEP_PEND_BIT]) pend_q = '0;
        if (!data[CTRL_KEEP_MASK_BIT]) mask_q = '0;
      end
      ACT_RD_STATUS: begin
        vstep_q   = VB_OPCODE;
        r.data    = pend_q & LINE_MASK;
        r.is_read = 1'b1;
      end
      ACT_RD_POLL: begin
        vstep_q   = VB_OPCODE;
        r.data    = take_poll_byte();
        r.is_read = 1'b1;
      end
      ACT_RD_VECTOR: begin
        r.is_read = 1'b1;
        if (dbg) begin
          r.data = vector_byte_at(vb_sel_t'(off));
        end else begin
          s = vstep_q;
          // the walk sticks at its end until a status or polling read
          if (s != VB_END && !frz) vstep_q = vb_sel_t'(s + 2'd1);
          r.data = vector_byte_at(s);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    read_res_t want_r;
    if (!rst_n) begin
      pend_q  <= LINE_MASK;
      mask_q  <= '0;
      page_q  <= '0;
      ivl_q   <= '0;
      base_q  <= '0;
      vstep_q <= VB_OPCODE;
      expected_reads_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reads_q.size() == 0) begin
          report_mismatch("result with no item waiting", out_read_data, 0);
        end else begin
          want_r = expected_reads_q.pop_front();
          if (out_read_data !== want_r.data)
            report_mismatch("read_data", out_read_data, want_r.data);
          if (out_read_valid !== want_r.is_read)
            report_mismatch("read_valid", out_read_valid, want_r.is_read);
        end
      end
      if (in_valid && in_ready)
        expected_reads_q.push_back(predict_access(in_action, in_write_data, in_line_index,
                                                  in_line_level, in_freeze_vector,
                                                  in_debug_access, in_debug_offset));
      if (end_check && expected_reads_q.size() != 0)
        report_mismatch("items left without result", expected_reads_q.size(), 0);
    end
    outstanding <= expected_reads_q.size();
  end

endmodule

/* test/tb_priority_interrupt_controller_core.sv */
`timescale 1ns / 100ps
// tb_priority_interrupt_controller_core: drives actions into the interrupt controller core,
// drains its results and gives the verdict; needs pic_pkg, the core and pic_core_checker
module tb_priority_interrupt_controller_core;
  import pic_pkg::*;

  // the action port is three bits wide; code seven is not a defined action
  localparam logic [2:0] ACT_SPARE = 3'd7;
  // receiver hold-off long enough to back the core up into its input
  localparam int RX_HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [7:0]  in_write_data;
  logic [2:0]  in_line_index;
  logic        in_line_level;
  logic        in_freeze_vector;
  logic        in_debug_access;
  logic [1:0]  in_debug_offset;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic        out_read_valid;
  logic        end_check;
  int unsigned outstanding;
  int unsigned error_count;

  // idle odds per cycle, in percent, for each side
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  priority_interrupt_controller_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_write_data    (in_write_data),
    .in_line_index    (in_line_index),
    .in_line_level    (in_line_level),
    .in_freeze_vector (in_freeze_vector),
    .in_debug_access  (in_debug_access),
    .in_debug_offset  (in_debug_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid)
  );

  pic_core_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_write_data    (in_write_data),
    .in_line_index    (in_line_index),
    .in_line_level    (in_line_level),
    .in_freeze_vector (in_freeze_vector),
    .in_debug_access  (in_debug_access),
    .in_debug_offset  (in_debug_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid),
    .end_check        (end_check),
    .outstanding      (outstanding),
    .error_count      (error_count)
  );

  // offer one item, idling first at the current odds, and hold it until taken
  task automatic send_item(input logic [2:0] act, input logic [7:0] data,
                           input logic [2:0] line, input logic lvl, input logic frz,
                           input logic dbg, input logic [1:0] off);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_write_data    <= data;
    in_line_index    <= line;
    in_line_level    <= lvl;
    in_freeze_vector <= frz;
    in_debug_access  <= dbg;
    in_debug_offset  <= off;
    do @(posedge clk); while (!in_ready);
  endtask

  // every field random; control writes mostly keep pending and mask so lines build up
  task automatic send_rand(input logic [2:0] act);
    logic [7:0] data;
    logic       lvl;
    data = 8'($urandom);
    if (act == ACT_WR_CTRL && $urandom_range(3) != 0) data[3:2] = 2'b11;
    lvl = ($urandom_range(9) < 7);
    send_item(act, data, 3'($urandom), lvl, $urandom_range(9) == 0, $urandom_range(9) == 0,
              2'($urandom));
  endtask

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 28) return ACT_LINE_REQ;
    if (r < 38) return ACT_WR_MASK;
    if (r < 43) return ACT_WR_PAGE;
    if (r < 51) return ACT_WR_CTRL;
    if (r < 61) return ACT_RD_STATUS;
    if (r < 76) return ACT_RD_POLL;
    if (r < 97) return ACT_RD_VECTOR;
    return ACT_SPARE;
  endfunction

  // mostly single actions; a quarter are vector walks started by a status or polling read
  task automatic run_phase(input int n_items);
    int sent;
    int walk_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 25) begin
        walk_len = $urandom_range(2, 5);
        send_rand($urandom_range(1) ? ACT_RD_POLL : ACT_RD_STATUS);
        repeat (walk_len) send_rand(ACT_RD_VECTOR);
        sent += 1 + walk_len;
      end else begin
        send_rand(pick_action());
        sent++;
      end
    end
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random ready, with an occasional long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    in_valid         = 1'b0;
    in_action        = ACT_LINE_REQ;
    in_write_data    = '0;
    in_line_index    = '0;
    in_line_level    = 1'b0;
    in_freeze_vector = 1'b0;
    in_debug_access  = 1'b0;
    in_debug_offset  = '0;
    end_check        = 1'b0;
    rst_n            = 1'b0;
    tx_idle_pct      = 31;
    rx_idle_pct      = 88;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, the full vector walk and its sticky end
    send_item(ACT_RD_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    // walk at its end returns zero, frozen or not
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b1, 1'b0, 2'd0);
    send_item(ACT_RD_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b1, 1'b0, 2'd0);
    // debug access by offset, freeze set on the first to show it has no effect there
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1, 2'd0);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1, 2'd1);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1, 2'd2);
    send_item(ACT_RD_VECTOR, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1, 2'd3);
    // register extremes: widest interval, top base nibble, alternate mask
    send_item(ACT_WR_PAGE, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_WR_CTRL, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_WR_MASK, 8'hAA, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_POLL, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_LINE_REQ, 8'h00, 3'd7, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_LINE_REQ, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 2'd0);
    // everything masked: poll falls back to line zero and clears nothing
    send_item(ACT_WR_MASK, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_POLL, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    // control of all zeros clears pending and mask
    send_item(ACT_WR_CTRL, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    // spare action code is ignored and gives a non-read result
    send_item(ACT_SPARE, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1, 2'd3);
    send_item(ACT_WR_CTRL, 8'h5E, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_item(ACT_LINE_REQ, 8'h00, 3'd5, 1'b1, 1'b0, 1'b0, 2'd0);
    send_item(ACT_RD_POLL, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0);

    // phase one: sender idles little, receiver a lot; pause in the middle until all is back
    run_phase(210);
    drain_results();
    run_phase(210);
    drain_results();

    // phase two: the other way round
    tx_idle_pct = 88;
    rx_idle_pct = 31;
    run_phase(400);
    drain_results();

    // phase three: no idling; a long receiver hold-off backs the core up into its input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    run_phase(410);
    drain_results();

    // let the last result settle, then have the checker look for leftovers
    repeat (4) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
